### hw/rtl/gcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gcs_pkg;

    // Field widths
    localparam int DATA_W    = 16;
    localparam int CHG_W     = 17;
    localparam int STATUS_W  = 2;

    // Denomination slots and how many are in use
    localparam int NUM_SLOTS = 4;
    localparam int NUM_DENOM = 4;
    localparam int LANE_W    = $clog2(NUM_SLOTS);

    // Divider pipelining: quotient bits resolved per stage
    localparam int STEP_BITS  = 2;
    localparam int DIV_STAGES = DATA_W / STEP_BITS;

    // Stream widths (whole bytes)
    localparam int IN_W      = 2 * DATA_W;
    localparam int OUT_BITS  = STATUS_W + CHG_W + NUM_SLOTS * DATA_W;
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

    typedef logic [LANE_W-1:0] t_lane;
    typedef logic [DATA_W-1:0] t_word;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_NEG   = 2'd2
    } t_status;

    // Denomination register reset values, largest first
    localparam t_word DENOM_RESET [NUM_SLOTS] = '{16'd10, 16'd5, 16'd2, 16'd1};

    // One request as it moves down the pipeline
    typedef struct packed {
        t_status                   status;
        logic signed [CHG_W-1:0]   change;
        logic [NUM_SLOTS-1:0][DATA_W-1:0] counts;
        t_word                     rest;
    } t_item;

endpackage

`default_nettype wire

### hw/rtl/greedy_change_splitter_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipeline from input accept to o_m_axis_tvalid: 1 front stage, 8 divider
//   stages per denomination, 1 output register.
// Throughput: one request per cycle while the output skid entry is empty;
//   each divider resolves 2 quotient bits per stage, so a full 16-bit
//   quotient spans 8 pipeline stages. Reset (synchronous, i_rst_n low):
//   pipeline and output empty, denominations load 10, 5, 2, 1.
module greedy_change_splitter_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration
    input  wire logic                        i_cfg_wr_en,
    input  wire gcs_pkg::t_lane              i_cfg_index,
    input  wire gcs_pkg::t_word              i_cfg_wdata,
    // request in
    input  wire logic                        i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [15:0] cash_paid, [31:16] amount_due
    input  wire logic [gcs_pkg::IN_W-1:0]    i_s_axis_tdata,
    // result out
    output logic                             o_m_axis_tvalid,
    input  wire logic                        i_m_axis_tready,
    // [1:0] status, [18:2] change_total, [34:19] count_first,
    // [50:35] count_second, [66:51] count_third, [82:67] count_fourth, rest 0
    output logic [gcs_pkg::OUT_W-1:0]        o_m_axis_tdata
);
    import gcs_pkg::*;

    // Denomination registers
    t_word r_denom [NUM_SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_denom <= DENOM_RESET;
        end else if (i_cfg_wr_en) begin
            r_denom[i_cfg_index] <= i_cfg_wdata;
        end
    end

    // Pipeline advance follows the output buffer
    logic w_en;
    assign o_s_axis_tready = w_en;

    // Front stage: change, status, dividend
    logic                    r_front_vld;
    t_item                   r_front;
    t_item                   n_front;
    logic signed [CHG_W-1:0] w_change;
    t_word                   w_paid;
    t_word                   w_due;

    assign w_paid   = i_s_axis_tdata[DATA_W-1:0];
    assign w_due    = i_s_axis_tdata[2*DATA_W-1:DATA_W];
    assign w_change = $signed({w_paid[DATA_W-1], w_paid})
                    - $signed({w_due[DATA_W-1], w_due});

    always_comb begin
        n_front        = '0;
        n_front.change = w_change;
        priority if (w_change[CHG_W-1]) begin
            n_front.status = ST_SHORT;
            n_front.rest   = '0;
        end else if (w_paid[DATA_W-1] || w_due[DATA_W-1]) begin
            n_front.status = ST_NEG;
            n_front.rest   = w_change[DATA_W-1:0];
        end else begin
            n_front.status = ST_OK;
            n_front.rest   = w_change[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_vld <= 1'b0;
        end else if (w_en) begin
            r_front_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_front <= n_front;
        end
    end

    // Divider chain, largest denomination first
    logic  [NUM_DENOM:0] w_vld;
    t_item               w_item [NUM_DENOM+1];

    assign w_vld[0]  = r_front_vld;
    assign w_item[0] = r_front;

    for (genvar g = 0; g < NUM_DENOM; g++) begin : g_div
        gcs_divider u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_denom (r_denom[g]),
            .i_lane  (t_lane'(g)),
            .i_vld   (w_vld[g]),
            .i_item  (w_item[g]),
            .o_vld   (w_vld[g+1]),
            .o_item  (w_item[g+1])
        );
    end

    // Output register with skid
    t_item w_out;

    gcs_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_vld[NUM_DENOM]),
        .o_rdy   (w_en),
        .i_item  (w_item[NUM_DENOM]),
        .o_vld   (o_m_axis_tvalid),
        .i_rdy   (i_m_axis_tready),
        .o_item  (w_out)
    );

    // Pack result fields
    always_comb begin
        o_m_axis_tdata                   = '0;
        o_m_axis_tdata[STATUS_W-1:0]     = w_out.status;
        o_m_axis_tdata[STATUS_W+CHG_W-1:STATUS_W] = w_out.change;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            o_m_axis_tdata[STATUS_W+CHG_W+k*DATA_W +: DATA_W] = w_out.counts[k];
        end
    end

    // Underpaid results carry no coins
    a_short_no_coins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && w_out.status == ST_SHORT) |-> (w_out.counts == '0))
        else $error("coins counted on insufficient payment");

    // Status agrees with the sign of the change
    a_status_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((w_out.status == ST_SHORT) == w_out.change[CHG_W-1]))
        else $error("status disagrees with change sign");

    // Pipeline only moves while the output side can take a result
    a_hold_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en && w_vld[NUM_DENOM]) |=> w_vld[NUM_DENOM])
        else $error("result dropped while output full");

endmodule

`default_nettype wire

### hw/rtl/gcs_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module gcs_divider (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire gcs_pkg::t_word i_denom,
    input  wire gcs_pkg::t_lane i_lane,
    input  wire logic           i_vld,
    input  wire gcs_pkg::t_item i_item,
    output logic                o_vld,
    output gcs_pkg::t_item      o_item
);
    import gcs_pkg::*;

    // Stage registers: partial remainder, dividend/quotient shift word, item
    logic  [DIV_STAGES-1:0] r_vld;
    t_word                  r_rem  [DIV_STAGES];
    t_word                  r_numq [DIV_STAGES];
    t_item                  r_item [DIV_STAGES];

    logic  [DIV_STAGES-1:0] n_vld;
    t_word                  n_rem  [DIV_STAGES];
    t_word                  n_numq [DIV_STAGES];
    t_item                  n_item [DIV_STAGES];

    // Restoring division, STEP_BITS quotient bits per stage
    always_comb begin
        logic [DATA_W:0] trial;
        t_word           rem_w;
        t_word           numq_w;
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (s == 0) begin
                n_vld[s]  = i_vld;
                n_item[s] = i_item;
                rem_w     = '0;
                numq_w    = i_item.rest;
            end else begin
                n_vld[s]  = r_vld[s-1];
                n_item[s] = r_item[s-1];
                rem_w     = r_rem[s-1];
                numq_w    = r_numq[s-1];
            end
            for (int b = 0; b < STEP_BITS; b++) begin
                trial  = {rem_w, numq_w[DATA_W-1]};
                numq_w = {numq_w[DATA_W-2:0], 1'b0};
                if (trial >= {1'b0, i_denom}) begin
                    rem_w     = DATA_W'(trial - {1'b0, i_denom});
                    numq_w[0] = 1'b1;
                end else begin
                    rem_w     = trial[DATA_W-1:0];
                end
            end
            n_rem[s]  = rem_w;
            n_numq[s] = numq_w;
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= n_vld;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_numq <= n_numq;
            r_item <= n_item;
        end
    end

    // Write this lane's count; a zero denomination counts nothing
    always_comb begin
        o_item                 = r_item[DIV_STAGES-1];
        o_item.counts[i_lane]  = (i_denom == '0) ? '0 : r_numq[DIV_STAGES-1];
        o_item.rest            = r_rem[DIV_STAGES-1];
    end

    assign o_vld = r_vld[DIV_STAGES-1];

    // Remainder stays below a nonzero divisor
    a_rem_below_denom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vld && i_denom != '0) |-> (o_item.rest < i_denom))
        else $error("remainder not below denominator");

    // Zero denomination passes the rest through unchanged
    a_zero_denom_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vld && i_denom == '0) |-> (o_item.rest == r_item[DIV_STAGES-1].rest))
        else $error("zero denomination altered remainder");

endmodule

`default_nettype wire

### hw/rtl/gcs_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none

module gcs_out_buf (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_vld,
    output logic                o_rdy,
    input  wire gcs_pkg::t_item i_item,
    output logic                o_vld,
    input  wire logic           i_rdy,
    output gcs_pkg::t_item      o_item
);
    import gcs_pkg::*;

    logic  r_out_vld;
    logic  r_skid_vld;
    t_item r_out;
    t_item r_skid;

    logic  n_out_vld;
    logic  n_skid_vld;
    logic  w_push;
    logic  w_pop;

    // Ready depends on registers only
    assign o_rdy  = ~r_skid_vld;
    assign w_push = i_vld & ~r_skid_vld;
    assign w_pop  = r_out_vld & i_rdy;

    // Output slot refills from skid first, then from the pipeline
    always_comb begin
        if (!r_out_vld || w_pop) begin
            n_out_vld  = r_skid_vld | w_push;
            n_skid_vld = 1'b0;
        end else begin
            n_out_vld  = 1'b1;
            n_skid_vld = r_skid_vld | w_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || w_pop) begin
            r_out <= r_skid_vld ? r_skid : i_item;
        end
        if (w_push && r_out_vld && !w_pop) begin
            r_skid <= i_item;
        end
    end

    assign o_vld  = r_out_vld;
    assign o_item = r_out;

    // Skid entry only exists behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry without output entry");

endmodule

`default_nettype wire
